// ----- sv/tsb_pkg.sv -----
// Shared types and constants for the texture slot batcher.
`timescale 1ns / 1ps
`default_nettype none
package tsb_pkg;

    localparam int SLOTS   = 32;
    localparam int ID_BITS = 32;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int USED_W  = $clog2(SLOTS + 1);
    localparam int QUAD_W  = 16;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    localparam logic REG_MAX_SLOTS = 1'b0;
    localparam logic REG_MAX_QUADS = 1'b1;

    localparam logic [USED_W-1:0] MAX_SLOTS_RST = USED_W'(32);
    localparam logic [QUAD_W-1:0] MAX_QUADS_RST = QUAD_W'(1024);

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [QUAD_W-1:0]  quads;
        logic [USED_W-1:0]  used;
    } res_t;

    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        logic [ID_BITS-1:0] id;
    } tbl_wr_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
    } tbl_hit_t;

endpackage
`default_nettype wire

// ----- sv/tsb_regs.sv -----
// APB configuration registers: max_slots and max_quads.
`timescale 1ns / 1ps
`default_nettype none
module tsb_regs
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tsb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tsb_pkg::DATA_W-1:0] pwdata,
    output logic      [tsb_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output logic      [tsb_pkg::USED_W-1:0] max_slots,
    output logic      [tsb_pkg::QUAD_W-1:0] max_quads
);

    logic [tsb_pkg::USED_W-1:0] max_slots_reg;
    logic [tsb_pkg::QUAD_W-1:0] max_quads_reg;
    logic                       wr_en;
    logic                       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slots_reg <= tsb_pkg::MAX_SLOTS_RST;
            max_quads_reg <= tsb_pkg::MAX_QUADS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tsb_pkg::REG_MAX_SLOTS: max_slots_reg <= pwdata[tsb_pkg::USED_W-1:0];
                tsb_pkg::REG_MAX_QUADS: max_quads_reg <= pwdata[tsb_pkg::QUAD_W-1:0];
                default:                max_quads_reg <= max_quads_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tsb_pkg::REG_MAX_SLOTS: prdata = tsb_pkg::DATA_W'(max_slots_reg);
            tsb_pkg::REG_MAX_QUADS: prdata = tsb_pkg::DATA_W'(max_quads_reg);
            default:                prdata = '0;
        endcase
    end

    assign max_slots = max_slots_reg;
    assign max_quads = max_quads_reg;

endmodule
`default_nettype wire

// ----- sv/tsb_slot_table.sv -----
// Slot identifier table with parallel lookup over the bound slots.
`timescale 1ns / 1ps
`default_nettype none
module tsb_slot_table
(
    input  wire logic                        clk,
    input  wire tsb_pkg::tbl_wr_t            wr,
    input  wire logic [tsb_pkg::ID_BITS-1:0] lookup_id,
    input  wire logic [tsb_pkg::USED_W-1:0]  used,
    output tsb_pkg::tbl_hit_t                hit
);

    logic [tsb_pkg::ID_BITS-1:0] ids_reg [tsb_pkg::SLOTS];
    logic [tsb_pkg::SLOTS-1:0]   match;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            ids_reg[wr.addr] <= wr.id;
    end

    // slot 0 is the white texture and never matches
    always_comb
    begin
        match[0] = 1'b0;
        for (int j = 1; j < tsb_pkg::SLOTS; j++)
            match[j] = (tsb_pkg::USED_W'(j) < used) && (ids_reg[j] == lookup_id);
    end

    always_comb
    begin
        hit.hit  = 1'b0;
        hit.slot = '0;
        for (int j = tsb_pkg::SLOTS - 1; j >= 1; j--)
        begin
            if (match[j])
            begin
                hit.hit  = 1'b1;
                hit.slot = tsb_pkg::SLOT_W'(j);
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/texture_slot_batcher_unit.sv -----
// Top level: texture slot batcher, request register, batch control and result buffer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | input     | in_valid / in_stall        | texture_id, end_of_frame
//  out     | output    | out_valid / out_stall      | result_kind, slot, batch_quads,
//          |           |                            | slots_used, last
//  cfg     | input     | APB psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// A request is registered, then looked up, assigned and turned into 1 to 3 results
// held in a result buffer; one result leaves per cycle while out_stall is low.
// Requests with one result run at one per cycle while the output is not stalled.
// Output stall backs up through the result buffer into the request register.
// Reset clears counters and valids; the slot table needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module texture_slot_batcher_unit
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [31:0]                texture_id,
    input  wire logic                       end_of_frame,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            result_kind,
    output logic      [4:0]                 slot,
    output logic      [15:0]                batch_quads,
    output logic      [5:0]                 slots_used,
    output logic                            last,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tsb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tsb_pkg::DATA_W-1:0] pwdata,
    output logic      [tsb_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam logic [tsb_pkg::QUAD_W-1:0] QUAD_SAT = '1;

    logic [tsb_pkg::USED_W-1:0]  max_slots;
    logic [tsb_pkg::QUAD_W-1:0]  max_quads;

    logic                        in_vld_reg;
    logic [tsb_pkg::ID_BITS-1:0] in_id_reg;
    logic                        in_eof_reg;

    logic [tsb_pkg::QUAD_W-1:0]  quads_reg, quads_next;
    logic [tsb_pkg::USED_W-1:0]  used_reg, used_next;

    logic                        buf_vld_reg;
    tsb_pkg::res_t               res_reg [3];
    tsb_pkg::res_t               res_next [3];
    logic [1:0]                  cnt_reg, cnt_next;
    logic [1:0]                  idx_reg;

    tsb_pkg::tbl_wr_t            tbl_wr;
    tsb_pkg::tbl_hit_t           tbl_hit;

    logic                        out_fire, buf_done, load, in_fire;
    logic [tsb_pkg::USED_W-1:0]  limit;
    logic                        flush_q, flush_s, pre_emit, id_nz, need_new;
    logic [tsb_pkg::QUAD_W-1:0]  q1, q2, q3;
    logic [tsb_pkg::USED_W-1:0]  s1, s2, s3;
    logic [tsb_pkg::SLOT_W-1:0]  slot_asg;
    tsb_pkg::res_t               r_pre, r_asg, r_eof;

    tsb_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_slots (max_slots),
        .max_quads (max_quads)
    );

    // quad-limit close empties the batch, so the lookup only sees slots after it
    tsb_slot_table u_table
    (
        .clk       (clk),
        .wr        (tbl_wr),
        .lookup_id (in_id_reg),
        .used      (s1),
        .hit       (tbl_hit)
    );

    assign out_fire = buf_vld_reg & ~out_stall;
    assign buf_done = out_fire & (idx_reg == cnt_reg);
    assign load     = in_vld_reg & (~buf_vld_reg | buf_done);
    assign in_stall = in_vld_reg & ~load;
    assign in_fire  = in_valid & ~in_stall;

    always_comb
    begin
        if (max_slots < tsb_pkg::USED_W'(2))
            limit = tsb_pkg::USED_W'(2);
        else if (max_slots > tsb_pkg::USED_W'(tsb_pkg::SLOTS))
            limit = tsb_pkg::USED_W'(tsb_pkg::SLOTS);
        else
            limit = max_slots;
    end

    always_comb
    begin
        id_nz    = (in_id_reg != '0);
        flush_q  = (quads_reg >= max_quads);
        q1       = flush_q ? '0 : quads_reg;
        s1       = flush_q ? tsb_pkg::USED_W'(1) : used_reg;
        need_new = id_nz & ~tbl_hit.hit;
        flush_s  = need_new & (s1 >= limit);
        q2       = flush_s ? '0 : q1;
        s2       = flush_s ? tsb_pkg::USED_W'(1) : s1;
        s3       = need_new ? s2 + tsb_pkg::USED_W'(1) : s1;
        q3       = (q2 < QUAD_SAT) ? q2 + tsb_pkg::QUAD_W'(1) : q2;
        pre_emit = (flush_q | flush_s) & (quads_reg != '0);

        if (need_new)
            slot_asg = s2[tsb_pkg::SLOT_W-1:0];
        else if (id_nz)
            slot_asg = tbl_hit.slot;
        else
            slot_asg = '0;

        tbl_wr.en   = load & need_new;
        tbl_wr.addr = s2[tsb_pkg::SLOT_W-1:0];
        tbl_wr.id   = in_id_reg;

        r_pre = '{kind: tsb_pkg::KIND_FLUSH, slot: '0, quads: quads_reg, used: used_reg};
        r_asg = '{kind: tsb_pkg::KIND_ASSIGN, slot: slot_asg, quads: '0, used: '0};
        r_eof = '{kind: tsb_pkg::KIND_FLUSH, slot: '0, quads: q3, used: s3};

        res_next[0] = pre_emit ? r_pre : r_asg;
        res_next[1] = pre_emit ? r_asg : r_eof;
        res_next[2] = r_eof;
        // count holds the index of the last result
        cnt_next    = 2'(pre_emit) + 2'(in_eof_reg);

        quads_next  = in_eof_reg ? '0 : q3;
        used_next   = in_eof_reg ? tsb_pkg::USED_W'(1) : s3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            buf_vld_reg <= 1'b0;
            quads_reg   <= '0;
            used_reg    <= tsb_pkg::USED_W'(1);
            cnt_reg     <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (in_fire)
                in_vld_reg <= 1'b1;
            else if (load)
                in_vld_reg <= 1'b0;

            if (load)
            begin
                buf_vld_reg <= 1'b1;
                cnt_reg     <= cnt_next;
                idx_reg     <= '0;
                quads_reg   <= quads_next;
                used_reg    <= used_next;
            end
            else if (buf_done)
                buf_vld_reg <= 1'b0;
            else if (out_fire)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_id_reg  <= texture_id[tsb_pkg::ID_BITS-1:0];
            in_eof_reg <= end_of_frame;
        end
        if (load)
        begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
            res_reg[2] <= res_next[2];
        end
    end

    assign out_valid   = buf_vld_reg;
    assign result_kind = res_reg[idx_reg].kind;
    assign slot        = res_reg[idx_reg].slot;
    assign batch_quads = res_reg[idx_reg].quads;
    assign slots_used  = res_reg[idx_reg].used;
    assign last        = (idx_reg == cnt_reg);

endmodule
`default_nettype wire

// ----- test/tsb_request_checker.sv -----
// Checker for the texture slot batcher: predicts slot and flush results and compares them.
`timescale 1ns / 1ps
module tsb_request_checker
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic [31:0]                texture_id,
    input  wire logic                       end_of_frame,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic                       result_kind,
    input  wire logic [4:0]                 slot,
    input  wire logic [15:0]                batch_quads,
    input  wire logic [5:0]                 slots_used,
    input  wire logic                       last,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic                       pready,
    input  wire logic [tsb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tsb_pkg::DATA_W-1:0] pwdata,
    output int                              mismatches,
    output int                              outstanding,
    output int                              requests_seen,
    output int                              results_seen,
    output int                              flushes_seen
);

    typedef struct packed {
        logic        kind;
        logic [4:0]  slot;
        logic [15:0] quads;
        logic [5:0]  used;
        logic        last;
    } batch_result_t;

    logic [31:0]   bound_ids [tsb_pkg::SLOTS];
    int            slots_bound;
    int            quads_in_batch;
    int            max_slots_cfg;
    int            max_quads_cfg;
    batch_result_t expected_results [$];
    batch_result_t want;
    int            fault_count;
    int            request_count;
    int            result_count;
    int            flush_count;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        fault_count++;
        $display("mismatch at %0t: %s got %0h exp %0h", $time, field, got, exp_val);
    endtask

    function automatic void push_result(input logic kind, input int slot_idx,
                                        input int quads, input int used);
        batch_result_t r;
        r.kind  = kind;
        r.slot  = 5'(slot_idx);
        r.quads = 16'(quads);
        r.used  = 6'(used);
        r.last  = 1'b0;
        expected_results = {expected_results, r};
    endfunction

    function automatic void close_batch();
        if (quads_in_batch != 0)
            push_result(tsb_pkg::KIND_FLUSH, 0, quads_in_batch, slots_bound);
        quads_in_batch = 0;
        slots_bound    = 1;
    endfunction

    function automatic void predict_quad(input logic [31:0] id, input logic eof);
        int limit;
        int hit_slot;
        int j;
        limit    = max_slots_cfg;
        hit_slot = 0;
        if (limit < 2)
            limit = 2;
        if (limit > tsb_pkg::SLOTS)
            limit = tsb_pkg::SLOTS;
        if (quads_in_batch >= max_quads_cfg)
            close_batch();
        if (id != 32'd0)
        begin
            for (j = 1; j < slots_bound && j < tsb_pkg::SLOTS; j++)
                if (hit_slot == 0 && bound_ids[j] == id)
                    hit_slot = j;
            if (hit_slot == 0)
            begin
                if (slots_bound >= limit)
                    close_batch();
                hit_slot = slots_bound;
                if (hit_slot < tsb_pkg::SLOTS)
                    bound_ids[hit_slot] = id;
                slots_bound++;
            end
        end
        if (quads_in_batch < 16'hFFFF)
            quads_in_batch++;
        push_result(tsb_pkg::KIND_ASSIGN, hit_slot, 0, 0);
        if (eof)
            close_batch();
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            slots_bound    = 1;
            quads_in_batch = 0;
            max_slots_cfg  = int'(tsb_pkg::MAX_SLOTS_RST);
            max_quads_cfg  = int'(tsb_pkg::MAX_QUADS_RST);
            fault_count    = 0;
            request_count  = 0;
            result_count   = 0;
            flush_count    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (result_kind == tsb_pkg::KIND_FLUSH)
                    flush_count++;
                if (expected_results.size() == 0)
                    report_mismatch("result with none expected, kind", result_kind, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result_kind !== want.kind)
                        report_mismatch("result_kind", result_kind, want.kind);
                    if (slot !== want.slot)
                        report_mismatch("slot", slot, want.slot);
                    if (batch_quads !== want.quads)
                        report_mismatch("batch_quads", batch_quads, want.quads);
                    if (slots_used !== want.used)
                        report_mismatch("slots_used", slots_used, want.used);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[tsb_pkg::ADDR_W-1:2] == tsb_pkg::REG_MAX_SLOTS)
                    max_slots_cfg = int'(pwdata[5:0]);
                else if (paddr[tsb_pkg::ADDR_W-1:2] == tsb_pkg::REG_MAX_QUADS)
                    max_quads_cfg = int'(pwdata[15:0]);
            end
            if (in_valid && !in_stall)
            begin
                request_count++;
                predict_quad(texture_id, end_of_frame);
            end
        end
        mismatches    <= fault_count;
        outstanding   <= expected_results.size();
        requests_seen <= request_count;
        results_seen  <= result_count;
        flushes_seen  <= flush_count;
    end

endmodule

// ----- test/tb_texture_slot_batcher_unit.sv -----
// Testbench top for the texture slot batcher: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_texture_slot_batcher_unit;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 150;

    typedef enum int { PRESS_NONE, PRESS_HOLD, PRESS_PAUSE } pressure_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic [31:0]                texture_id;
    logic                       end_of_frame;
    logic                       out_stall;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [tsb_pkg::ADDR_W-1:0] paddr;
    logic [tsb_pkg::DATA_W-1:0] pwdata;
    wire logic                  in_stall;
    wire logic                  out_valid;
    wire logic                  result_kind;
    wire logic [4:0]            slot;
    wire logic [15:0]           batch_quads;
    wire logic [5:0]            slots_used;
    wire logic                  last;
    wire logic [tsb_pkg::DATA_W-1:0] prdata;
    wire logic                  pready;

    int mismatches;
    int outstanding;
    int requests_seen;
    int results_seen;
    int flushes_seen;
    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int quiet_cycles;

    texture_slot_batcher_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .texture_id   (texture_id),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .slot         (slot),
        .batch_quads  (batch_quads),
        .slots_used   (slots_used),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tsb_request_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .texture_id    (texture_id),
        .end_of_frame  (end_of_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .slot          (slot),
        .batch_quads   (batch_quads),
        .slots_used    (slots_used),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .flushes_seen  (flushes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall, or a counted hold-off when requested
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no activity for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(input logic [31:0] id, input logic eof);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        texture_id   <= id;
        end_of_frame <= eof;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input int slots, input int quads);
        write_reg(tsb_pkg::REG_MAX_SLOTS, 32'(slots));
        write_reg(tsb_pkg::REG_MAX_QUADS, 32'(quads));
    endtask

    task automatic run_phase(input int slots, input int quads, input int send_pct,
                             input int stall_p, input int count, input int fresh_pct,
                             input int eof_pct, input pressure_t pressure);
        logic [31:0] pool [8];
        logic [31:0] id;
        int          pool_n;
        int          r;
        int          i;
        wait_drained();
        set_limits(slots, quads);
        send_idle_pct = send_pct;
        stall_pct     = stall_p;
        pool_n        = $urandom_range(8, 3);
        for (i = 0; i < 8; i++)
            do pool[i] = $urandom; while (pool[i] == 32'd0);
        if (pressure == PRESS_HOLD)
            hold_left = HOLD_CYCLES;
        for (i = 0; i < count; i++)
        begin
            if (pressure == PRESS_PAUSE && i == count / 2)
                wait_drained();
            r = $urandom_range(99);
            if (r < 15)
                id = 32'd0;
            else if (r < 15 + fresh_pct)
                id = $urandom;
            else
                id = pool[$urandom_range(pool_n - 1)];
            send_request(id, $urandom_range(99) < eof_pct);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        texture_id    <= 32'd0;
        end_of_frame  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        quiet_cycles  <= 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: white slot, new slots, hits, end-of-frame close
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h0000_0001, 1'b1);

        // two slots, three quads: slot-full close, quad-limit close, three results
        wait_drained();
        set_limits(2, 3);
        send_request(32'd5, 1'b0);
        send_request(32'd6, 1'b0);
        send_request(32'd6, 1'b0);
        send_request(32'd0, 1'b0);
        send_request(32'd7, 1'b1);

        // limits lowered below an open batch
        wait_drained();
        set_limits(32, 1024);
        send_request(32'd9, 1'b0);
        send_request(32'd10, 1'b0);
        send_request(32'd11, 1'b0);
        wait_drained();
        write_reg(tsb_pkg::REG_MAX_SLOTS, 32'd3);
        send_request(32'd12, 1'b0);
        wait_drained();
        write_reg(tsb_pkg::REG_MAX_QUADS, 32'd1);
        send_request(32'd12, 1'b0);
        send_request(32'd0, 1'b0);

        // slot limit below two, zero quad limit, empty batch close
        wait_drained();
        set_limits(1, 0);
        send_request(32'd13, 1'b1);
        send_request(32'd0, 1'b1);
        send_request(32'd13, 1'b0);
        send_request(32'd14, 1'b0);

        run_phase(32, 1024, 0, 0, 24, 10, 8, PRESS_NONE);
        run_phase(2, 1, 69, 0, 24, 20, 5, PRESS_NONE);
        run_phase(3, 4, 0, 69, 24, 20, 10, PRESS_HOLD);
        run_phase(63, 0, 13, 13, 20, 30, 5, PRESS_NONE);
        run_phase(1, 2, 0, 0, 20, 20, 5, PRESS_PAUSE);
        run_phase(8, 65535, 69, 0, 28, 40, 3, PRESS_NONE);
        run_phase(32, 1024, 0, 69, 48, 85, 0, PRESS_NONE);
        run_phase(33, 16, 0, 69, 24, 20, 5, PRESS_PAUSE);
        run_phase(0, 3, 13, 13, 20, 20, 10, PRESS_NONE);
        run_phase(16, 50, 69, 0, 24, 50, 2, PRESS_HOLD);

        stall_pct = 0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Ran %0d quad requests through %0d results (%0d batch flushes),",
                 requests_seen, results_seen, flushes_seen);
        $display("over slot limits 0..63, quad limits 0..65535, stalls, gaps and back-pressure.");
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tsb_pkg.sv
sv/tsb_regs.sv
sv/tsb_slot_table.sv
sv/texture_slot_batcher_unit.sv
test/tsb_request_checker.sv
test/tb_texture_slot_batcher_unit.sv
